@@ rtl/aqpt_pkg.sv @@
package aqpt_pkg;

    localparam int unsigned DEF_RING_SLOTS = 32;

    localparam logic [31:0] TIMEOUT_RESET = 32'd10_000_000;
    localparam logic [15:0] FIRST_ID      = 16'd1;

    localparam int unsigned SLOT_W     = 5;
    localparam int unsigned IN_TDATA_W = 64;
    localparam int unsigned IN_TUSER_W = 2;
    localparam int unsigned OUT_TDATA_W = 80;
    localparam int unsigned OUT_TUSER_W = 5;

    typedef enum logic [1:0] {
        MODE_SUBMIT   = 2'd0,
        MODE_COMPLETE = 2'd1,
        MODE_TICK     = 2'd2,
        MODE_RESTART  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OUT_OK          = 3'd0,
        OUT_PENDING     = 3'd1,
        OUT_TIMEOUT     = 3'd2,
        OUT_ID_MISMATCH = 3'd3,
        OUT_FAILED      = 3'd4,
        OUT_NOT_WAITING = 3'd5,
        OUT_BUSY        = 3'd6
    } t_outcome;

    typedef enum logic [1:0] {
        DB_NONE = 2'd0,
        DB_TAIL = 2'd1,
        DB_HEAD = 2'd2
    } t_db_kind;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] entry_status;
        logic [15:0] entry_command_id;
        logic [31:0] entry_result;
    } t_in_item;

    typedef struct packed {
        t_outcome          outcome;
        logic [15:0]       issued_id;
        t_db_kind          doorbell_kind;
        logic [SLOT_W-1:0] doorbell_value;
        logic [SLOT_W-1:0] head_slot;
        logic [31:0]       result_dword;
        logic [14:0]       fail_status;
    } t_out_item;

endpackage

@@ rtl/aqpt_in_stage.sv @@
module aqpt_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    output logic               o_rdy,
    input  aqpt_pkg::t_in_item i_item,
    output logic               o_vld,
    input  logic               i_take,
    output aqpt_pkg::t_in_item o_item
);
    import aqpt_pkg::*;

    logic     r_vld;
    t_in_item r_item;

    // Refill in the same cycle the held beat moves on.
    assign o_rdy  = !r_vld || i_take;
    assign o_vld  = r_vld;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_item <= i_item;
        end
    end

endmodule

@@ rtl/aqpt_step.sv @@
module aqpt_step #(
    parameter int unsigned RING_SLOTS = aqpt_pkg::DEF_RING_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    input  logic                i_fire,
    input  aqpt_pkg::t_in_item  i_item,
    output aqpt_pkg::t_out_item o_item
);
    import aqpt_pkg::*;

    localparam int unsigned PTR_W = $clog2(RING_SLOTS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_SLOTS - 1);

    logic [31:0]      r_timeout;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [PTR_W-1:0] r_head, n_head;
    logic [15:0]      r_next_id, n_next_id;
    logic             r_phase, n_phase;
    logic [15:0]      r_pend_id, n_pend_id;
    logic             r_awaiting, n_awaiting;
    logic [31:0]      r_wait, n_wait;

    logic [PTR_W-1:0]      tail_inc;
    logic [PTR_W-1:0]      head_inc;
    logic [31:0]           wait_inc;
    logic [PTR_W+SLOT_W-1:0] db_ext;
    logic [PTR_W+SLOT_W-1:0] head_ext;
    logic [PTR_W-1:0]      db_ptr;
    logic [14:0]           fstat;

    assign tail_inc = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
    assign head_inc = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
    assign wait_inc = (r_wait == '1) ? r_wait : r_wait + 32'd1;
    assign fstat    = i_item.entry_status[15:1];

    always_comb begin
        n_tail     = r_tail;
        n_head     = r_head;
        n_next_id  = r_next_id;
        n_phase    = r_phase;
        n_pend_id  = r_pend_id;
        n_awaiting = r_awaiting;
        n_wait     = r_wait;
        db_ptr     = '0;

        o_item                = '0;
        o_item.outcome        = OUT_OK;
        o_item.doorbell_kind  = DB_NONE;

        case (i_item.mode)
            MODE_SUBMIT: begin
                if (r_awaiting) begin
                    o_item.outcome = OUT_BUSY;
                end else begin
                    o_item.issued_id     = r_next_id;
                    n_pend_id            = r_next_id;
                    n_next_id            = r_next_id + 16'd1;
                    n_tail               = tail_inc;
                    n_awaiting           = 1'b1;
                    n_wait               = '0;
                    o_item.doorbell_kind = DB_TAIL;
                    db_ptr               = tail_inc;
                end
            end
            MODE_COMPLETE: begin
                if (!r_awaiting) begin
                    o_item.outcome = OUT_NOT_WAITING;
                end else if (i_item.entry_status[0] != r_phase) begin
                    o_item.outcome = OUT_PENDING;
                end else if (i_item.entry_command_id != r_pend_id) begin
                    o_item.outcome = OUT_ID_MISMATCH;
                    n_awaiting     = 1'b0;
                end else begin
                    n_head               = head_inc;
                    n_phase              = (head_inc == '0) ? !r_phase : r_phase;
                    n_awaiting           = 1'b0;
                    o_item.doorbell_kind = DB_HEAD;
                    db_ptr               = head_inc;
                    o_item.result_dword  = i_item.entry_result;
                    o_item.fail_status   = fstat;
                    o_item.outcome       = (fstat != '0) ? OUT_FAILED : OUT_OK;
                end
            end
            MODE_TICK: begin
                if (!r_awaiting) begin
                    o_item.outcome = OUT_NOT_WAITING;
                end else begin
                    n_wait = wait_inc;
                    if (wait_inc > r_timeout) begin
                        o_item.outcome = OUT_TIMEOUT;
                        n_awaiting     = 1'b0;
                    end else begin
                        o_item.outcome = OUT_PENDING;
                    end
                end
            end
            default: begin
                n_tail     = '0;
                n_head     = '0;
                n_next_id  = FIRST_ID;
                n_phase    = 1'b1;
                n_pend_id  = '0;
                n_awaiting = 1'b0;
                n_wait     = '0;
            end
        endcase

        db_ext                = {{SLOT_W{1'b0}}, db_ptr};
        head_ext              = {{SLOT_W{1'b0}}, n_head};
        o_item.doorbell_value = db_ext[SLOT_W-1:0];
        o_item.head_slot      = head_ext[SLOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail     <= '0;
            r_head     <= '0;
            r_next_id  <= FIRST_ID;
            r_phase    <= 1'b1;
            r_pend_id  <= '0;
            r_awaiting <= 1'b0;
            r_wait     <= '0;
        end else if (i_fire) begin
            r_tail     <= n_tail;
            r_head     <= n_head;
            r_next_id  <= n_next_id;
            r_phase    <= n_phase;
            r_pend_id  <= n_pend_id;
            r_awaiting <= n_awaiting;
            r_wait     <= n_wait;
        end
    end

`ifndef ASSERT_OFF
    a_submit_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.mode == MODE_SUBMIT && !r_awaiting
        |=> r_awaiting && r_wait == '0 && r_pend_id == $past(r_next_id))
        else $error("submit did not arm the wait");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.mode == MODE_RESTART
        |=> !r_awaiting && r_head == '0 && r_tail == '0 && r_phase)
        else $error("restart left pointers behind");

    a_doorbell_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item.doorbell_kind != DB_NONE
        |-> o_item.outcome == OUT_OK || o_item.outcome == OUT_FAILED)
        else $error("doorbell on a failing outcome");

    a_head_moves_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_head != n_head
        |-> o_item.doorbell_kind == DB_HEAD || i_item.mode == MODE_RESTART)
        else $error("head moved without a head doorbell");
`endif

endmodule

@@ rtl/aqpt_out_stage.sv @@
module aqpt_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    output logic                o_rdy,
    input  aqpt_pkg::t_out_item i_item,
    output logic                o_vld,
    input  logic                i_rdy,
    output aqpt_pkg::t_out_item o_item
);
    import aqpt_pkg::*;

    logic      r_vld;
    t_out_item r_item;

    assign o_rdy  = !r_vld || i_rdy;
    assign o_vld  = r_vld;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_item <= i_item;
        end
    end

endmodule

@@ rtl/admin_queue_phase_tracker_core.sv @@
// Host-side admin queue tracker for one command in flight. Each input beat is a
// submit, a completion entry seen at the head slot, a timer tick or a restart;
// each gives exactly one result beat with the outcome, the id issued, the doorbell
// to write (tail or head, and its value), the head slot to poll next, and on a
// matched completion the result dword and status>>1. The block takes one beat
// per clock while results are taken: a beat lands in the input register, the
// step logic reads the tracker state, and on the next edge the result register
// loads while the state updates, so the following beat already sees it. A
// result passes through the input register and then the result register; a
// stalled result register still lets one more beat wait in the input register
// before s_tready drops. Write timeout_ticks only while no beat is in flight; a
// wait times out on the tick that brings the count above it.
module admin_queue_phase_tracker_core #(
    parameter int unsigned RING_SLOTS = aqpt_pkg::DEF_RING_SLOTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: timeout_ticks
    input  logic                              i_cfg_we,
    input  logic [31:0]                       i_cfg_wdata,
    // input beats
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] entry_status, [31:16] entry_command_id, [63:32] entry_result
    input  logic [aqpt_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [1:0] mode
    input  logic [aqpt_pkg::IN_TUSER_W-1:0]   s_tuser,
    // result beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] issued_id, [20:16] doorbell_value, [25:21] head_slot,
    // [57:26] result_dword, [72:58] fail_status, [79:73] zero
    output logic [aqpt_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // [2:0] outcome, [4:3] doorbell_kind
    output logic [aqpt_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import aqpt_pkg::*;

    t_in_item  in_item;
    t_in_item  held_item;
    t_out_item step_item;
    t_out_item res_item;
    logic      held_vld;
    logic      res_rdy;
    logic      fire;

    // Unpack the input beat into the item struct.
    always_comb begin
        in_item.mode             = t_mode'(s_tuser[1:0]);
        in_item.entry_status     = s_tdata[15:0];
        in_item.entry_command_id = s_tdata[31:16];
        in_item.entry_result     = s_tdata[63:32];
    end

    // Advance a held beat whenever the result register can take its result.
    assign fire = held_vld && res_rdy;

    aqpt_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_tvalid),
        .o_rdy   (s_tready),
        .i_item  (in_item),
        .o_vld   (held_vld),
        .i_take  (res_rdy),
        .o_item  (held_item)
    );

    aqpt_step #(
        .RING_SLOTS (RING_SLOTS)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (held_item),
        .o_item      (step_item)
    );

    aqpt_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (held_vld),
        .o_rdy   (res_rdy),
        .i_item  (step_item),
        .o_vld   (m_tvalid),
        .i_rdy   (m_tready),
        .o_item  (res_item)
    );

    // Pack the result beat; pad tdata to whole bytes with zeros.
    assign m_tdata = {7'd0, res_item.fail_status, res_item.result_dword,
                      res_item.head_slot, res_item.doorbell_value, res_item.issued_id};
    assign m_tuser = {res_item.doorbell_kind, res_item.outcome};

endmodule
